// File: src/lspm_pkg.sv
package lspm_pkg;

   // Field widths
   localparam int NORMAL_W = 16;
   localparam int OFFSET_W = 32;
   localparam int NN_W     = 36;
   localparam int DN_W     = 52;
   localparam int FLOOR_W  = 36;
   localparam int CORNER_W = 32;
   localparam int REQ_DATA_W = 3 * NORMAL_W + OFFSET_W;
   localparam int RSP_DATA_W = 3 * CORNER_W;

   // Depth of the queue between front and back
   localparam int QDEPTH = 2;

   // One plane as held in the queue, already classified
   typedef struct packed {
      logic signed [NORMAL_W-1:0] nx;
      logic signed [NORMAL_W-1:0] ny;
      logic signed [NORMAL_W-1:0] nz;
      logic signed [OFFSET_W-1:0] offset;
      logic                       acc_en;
      logic                       final_plane;
   } item_type;

   // Normal-equation sums
   typedef struct packed {
      logic [NN_W-1:0] xx;
      logic [NN_W-1:0] xy;
      logic [NN_W-1:0] xz;
      logic [NN_W-1:0] yy;
      logic [NN_W-1:0] yz;
      logic [NN_W-1:0] zz;
      logic [DN_W-1:0] dx;
      logic [DN_W-1:0] dy;
      logic [DN_W-1:0] dz;
   } sums_type;

   // Solved corner
   typedef struct packed {
      logic [CORNER_W-1:0] x;
      logic [CORNER_W-1:0] y;
      logic [CORNER_W-1:0] z;
      logic                solved;
   } result_type;

endpackage

// File: src/least_squares_plane_meet_top.sv
// Least-squares meet of a run of planes.
// req_ channel: one plane per transfer, normals Q1.14 and offset Q16.16 in
// req_tdata, req_tlast on the last plane of a set. rsp_ channel: one transfer
// per set, the corner in Q16.16 in rsp_tdata and rsp_tuser high if solved.
// csr_ channel: write of the pivot floor, taken at any cycle; write it only
// while no set is in flight.
// Planes are registered in a two-entry queue and are accumulated from it at
// one per cycle while the sums are not held for the solver. The last plane
// hands the sums to the solver, which copies the twelve matrix entries;
// accumulation of the next set then resumes while the solve runs. The solve
// uses one shared multiply-divide unit (four partial products, then one
// quotient bit per cycle) up to 21 times, fewer when the matrix has zero
// entries or a pivot fails.
// Reset clears the sums, the plane count and the queue and sets the floor to
// 1. While rsp_tready is low the result holds in the output register; the
// solver then waits, the queue fills, and req_tready drops.
module least_squares_plane_meet_top #(
   parameter int MAX_PLANES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // normal_x [15:0], normal_y [31:16], normal_z [47:32], offset [79:48]
   input  logic [lspm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // corner_x [31:0], corner_y [63:32], corner_z [95:64]
   output logic [lspm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // solved [0]
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lspm_pkg::FLOOR_W-1:0]       csr_data
);

   logic                            q_valid, q_pop;
   lspm_pkg::item_type              q_item;
   lspm_pkg::sums_type              sums;
   logic                            solve_req, load_done;
   logic                            res_valid, res_take;
   lspm_pkg::result_type            res;
   logic [lspm_pkg::FLOOR_W-1:0]    floor_ff;
   logic                            rsp_valid_ff;
   logic [lspm_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_user_ff;

   lspm_front #(.MaxPlanes(MAX_PLANES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .in_last  (req_tlast),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   lspm_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .sums      (sums),
      .solve_req (solve_req),
      .load_done (load_done)
   );

   lspm_solver u_solver (
      .clock       (clock),
      .reset       (reset),
      .solve_req   (solve_req),
      .sums        (sums),
      .pivot_floor (floor_ff),
      .load_done   (load_done),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   // Pivot floor register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= lspm_pkg::FLOOR_W'(1);
      end else if (csr_valid) begin
         floor_ff <= csr_data;
      end
   end

   // Output register
   assign res_take   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take && res_valid) begin
         rsp_data_ff <= {res.z, res.y, res.x};
         rsp_user_ff <= res.solved;
      end
   end

`ifndef SYNTHESIS
   a_sums_frozen: assert property (@(posedge clock) disable iff (reset)
      solve_req && !load_done |=> $stable(sums))
      else $error("sums changed while held for the solver");

   a_load_needs_req: assert property (@(posedge clock) disable iff (reset)
      load_done |-> solve_req)
      else $error("solver load finished without a pending set");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_take |=> res_valid && $stable(res))
      else $error("solver result dropped before transfer");
`endif

endmodule

// File: src/lspm_front.sv
module lspm_front #(
   parameter int MaxPlanes = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [lspm_pkg::REQ_DATA_W-1:0]      in_data,
   input  logic                                 in_last,
   output logic                                 q_valid,
   output lspm_pkg::item_type                   q_item,
   input  logic                                 q_pop
);

   localparam int CntW = $clog2(MaxPlanes + 1);
   localparam int PtrW = (lspm_pkg::QDEPTH > 1) ? $clog2(lspm_pkg::QDEPTH) : 1;
   localparam int FillW = $clog2(lspm_pkg::QDEPTH + 1);

   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [PtrW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [FillW-1:0]   fill_ff, fill_in;
   lspm_pkg::item_type mem_ff [lspm_pkg::QDEPTH];
   lspm_pkg::item_type new_item;
   logic               push, pop;

   assign in_ready = (fill_ff != FillW'(lspm_pkg::QDEPTH));
   assign q_valid  = (fill_ff != '0);
   assign q_item   = mem_ff[rptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   // Classify: planes past the limit are not accumulated
   always_comb begin
      new_item.nx          = in_data[15:0];
      new_item.ny          = in_data[31:16];
      new_item.nz          = in_data[47:32];
      new_item.offset      = in_data[79:48];
      new_item.acc_en      = (cnt_ff < CntW'(MaxPlanes));
      new_item.final_plane = in_last;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         if (in_last) begin
            cnt_in = '0;
         end else if (new_item.acc_en) begin
            cnt_in = cnt_ff + CntW'(1);
         end
         wptr_in = (wptr_ff == PtrW'(lspm_pkg::QDEPTH - 1)) ? '0 : wptr_ff + PtrW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PtrW'(lspm_pkg::QDEPTH - 1)) ? '0 : rptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FillW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= new_item;
      end
   end

endmodule

// File: src/lspm_accum.sv
module lspm_accum (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lspm_pkg::item_type  q_item,
   output logic                q_pop,
   output lspm_pkg::sums_type  sums,
   output logic                solve_req,
   input  logic                load_done
);

   lspm_pkg::sums_type sums_ff, sums_in;
   logic               hold_ff, hold_in;
   logic signed [31:0] pxx, pxy, pxz, pyy, pyz, pzz;
   logic signed [47:0] pdx, pdy, pdz;

   assign q_pop     = q_valid && !hold_ff;
   assign sums      = sums_ff;
   assign solve_req = hold_ff;

   // Products of one plane
   always_comb begin
      pxx = $signed(q_item.nx) * $signed(q_item.nx);
      pxy = $signed(q_item.nx) * $signed(q_item.ny);
      pxz = $signed(q_item.nx) * $signed(q_item.nz);
      pyy = $signed(q_item.ny) * $signed(q_item.ny);
      pyz = $signed(q_item.ny) * $signed(q_item.nz);
      pzz = $signed(q_item.nz) * $signed(q_item.nz);
      pdx = $signed(q_item.offset) * $signed(q_item.nx);
      pdy = $signed(q_item.offset) * $signed(q_item.ny);
      pdz = $signed(q_item.offset) * $signed(q_item.nz);
   end

   // Sums wrap at their widths; cleared once the solver holds a copy
   always_comb begin
      sums_in = sums_ff;
      hold_in = hold_ff;
      if (hold_ff && load_done) begin
         sums_in = '0;
         hold_in = 1'b0;
      end else if (q_pop) begin
         if (q_item.acc_en) begin
            sums_in.xx = sums_ff.xx + {{4{pxx[31]}}, pxx};
            sums_in.xy = sums_ff.xy + {{4{pxy[31]}}, pxy};
            sums_in.xz = sums_ff.xz + {{4{pxz[31]}}, pxz};
            sums_in.yy = sums_ff.yy + {{4{pyy[31]}}, pyy};
            sums_in.yz = sums_ff.yz + {{4{pyz[31]}}, pyz};
            sums_in.zz = sums_ff.zz + {{4{pzz[31]}}, pzz};
            sums_in.dx = sums_ff.dx + {{4{pdx[47]}}, pdx};
            sums_in.dy = sums_ff.dy + {{4{pdy[47]}}, pdy};
            sums_in.dz = sums_ff.dz + {{4{pdz[47]}}, pdz};
         end
         hold_in = q_item.final_plane;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
         hold_ff <= 1'b0;
      end else begin
         sums_ff <= sums_in;
         hold_ff <= hold_in;
      end
   end

endmodule

// File: src/lspm_muldiv.sv
module lspm_muldiv (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   input  logic [63:0]  op_d,
   output logic         done,
   output logic [127:0] quo
);

   // Computes floor((a * b + floor(d / 2)) / d): four partial products,
   // then one quotient bit per cycle
   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_MUL  = 3'b010,
      M_DIV  = 3'b100
   } mstate_type;

   mstate_type   st_ff, st_in;
   logic [6:0]   step_ff, step_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in, d_ff, d_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  rem_ff, rem_in;
   logic         done_ff, done_in;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [64:0]  rem_sh, rem_sub;
   logic         ge;

   assign done = done_ff;
   assign quo  = acc_ff;

   always_comb begin
      a_half  = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half  = step_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp      = a_half * b_half;
      case (step_ff[1:0])
         2'd0:    pp_sh = {64'd0, pp};
         2'd1:    pp_sh = {32'd0, pp, 32'd0};
         2'd2:    pp_sh = {32'd0, pp, 32'd0};
         default: pp_sh = {pp, 64'd0};
      endcase
      rem_sh  = {rem_ff, acc_ff[127]};
      rem_sub = rem_sh - {1'b0, d_ff};
      ge      = (rem_sh >= {1'b0, d_ff});
   end

   always_comb begin
      st_in   = st_ff;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      d_in    = d_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      case (st_ff)
         M_IDLE: begin
            if (start) begin
               a_in    = op_a;
               b_in    = op_b;
               d_in    = op_d;
               acc_in  = {65'd0, op_d[63:1]};
               rem_in  = '0;
               step_in = '0;
               st_in   = M_MUL;
            end
         end
         M_MUL: begin
            acc_in = acc_ff + pp_sh;
            if (step_ff == 7'd3) begin
               step_in = '0;
               st_in   = M_DIV;
            end else begin
               step_in = step_ff + 7'd1;
            end
         end
         M_DIV: begin
            rem_in = ge ? rem_sub[63:0] : rem_sh[63:0];
            acc_in = {acc_ff[126:0], ge};
            if (step_ff == 7'd127) begin
               done_in = 1'b1;
               st_in   = M_IDLE;
            end else begin
               step_in = step_ff + 7'd1;
            end
         end
         default: st_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= M_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

endmodule

// File: src/lspm_solver.sv
module lspm_solver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            solve_req,
   input  lspm_pkg::sums_type              sums,
   input  logic [lspm_pkg::FLOOR_W-1:0]    pivot_floor,
   output logic                            load_done,
   output logic                            res_valid,
   output lspm_pkg::result_type            res,
   input  logic                            res_take
);

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } ent_type;

   typedef enum logic [20:0] {
      S_IDLE  = 21'h000001,
      S_LOAD  = 21'h000002,
      S_PRD   = 21'h000004,
      S_PCMP  = 21'h000008,
      S_PCHK  = 21'h000010,
      S_SWA   = 21'h000020,
      S_SWB   = 21'h000040,
      S_SWC   = 21'h000080,
      S_SWD   = 21'h000100,
      S_EF    = 21'h000200,
      S_EFL   = 21'h000400,
      S_EB    = 21'h000800,
      S_EA    = 21'h001000,
      S_EMUL  = 21'h002000,
      S_EWAIT = 21'h004000,
      S_FA    = 21'h008000,
      S_FD    = 21'h010000,
      S_FMUL  = 21'h020000,
      S_FWAIT = 21'h040000,
      S_OUT   = 21'h080000,
      S_SPARE = 21'h100000
   } state_type;

   function automatic ent_type to_ent(input logic [63:0] v);
      ent_type e;
      e.neg = v[63];
      e.mag = v[63] ? (~v + 64'd1) : v;
      return e;
   endfunction

   localparam logic [127:0] LIM64_POS = {65'd0, {63{1'b1}}};
   localparam logic [127:0] LIM64_NEG = {64'd0, 1'b1, 63'd0};
   localparam logic [127:0] LIM32_POS = {97'd0, {31{1'b1}}};
   localparam logic [127:0] LIM32_NEG = {96'd0, 1'b1, 31'd0};

   state_type   st_ff, st_in;
   logic [3:0]  lcnt_ff, lcnt_in;
   logic [1:0]  col_ff, col_in, row_ff, row_in, k_ff, k_in, piv_ff, piv_in;
   ent_type     best_ff, best_in, f_ff, f_in, bk_ff, bk_in, a_ff, a_in, tmp_ff, tmp_in;
   logic [31:0] corner_ff [3];
   logic [31:0] corner_val;
   logic        corner_wr, corner_clr;
   logic        ok_ff, ok_in;

   // Working matrix, row-major with four columns per row
   ent_type     mem_ff [12];
   ent_type     rd_data_ff;
   logic [3:0]  rd_addr, wr_addr;
   logic        wr_en;
   ent_type     wr_data;

   logic [63:0]  load_val;
   logic [1:0]   last_row, row_step, first_row;
   logic         md_start, md_done;
   logic [63:0]  md_a, md_b, md_d;
   logic [127:0] md_q;

   // Elimination update and output saturation
   logic         sneg, sub_neg, fin_neg;
   logic [127:0] am, sub_m, sub_lim, fin_lim;
   ent_type      sub_res;
   logic [31:0]  fin_v;

   lspm_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .op_a  (md_a),
      .op_b  (md_b),
      .op_d  (md_d),
      .done  (md_done),
      .quo   (md_q)
   );

   // Source of each matrix entry at load
   always_comb begin
      case (lcnt_ff)
         4'd0:    load_val = {{28{sums.xx[35]}}, sums.xx};
         4'd1:    load_val = {{28{sums.xy[35]}}, sums.xy};
         4'd2:    load_val = {{28{sums.xz[35]}}, sums.xz};
         4'd3:    load_val = {{12{sums.dx[51]}}, sums.dx};
         4'd4:    load_val = {{28{sums.xy[35]}}, sums.xy};
         4'd5:    load_val = {{28{sums.yy[35]}}, sums.yy};
         4'd6:    load_val = {{28{sums.yz[35]}}, sums.yz};
         4'd7:    load_val = {{12{sums.dy[51]}}, sums.dy};
         4'd8:    load_val = {{28{sums.xz[35]}}, sums.xz};
         4'd9:    load_val = {{28{sums.yz[35]}}, sums.yz};
         4'd10:   load_val = {{28{sums.zz[35]}}, sums.zz};
         4'd11:   load_val = {{12{sums.dz[51]}}, sums.dz};
         default: load_val = '0;
      endcase
   end

   // Row walk for elimination skips the pivot row
   always_comb begin
      last_row  = (col_ff == 2'd2) ? 2'd1 : 2'd2;
      first_row = (col_ff == 2'd0) ? 2'd1 : 2'd0;
      row_step  = ((row_ff + 2'd1) == col_ff) ? row_ff + 2'd2 : row_ff + 2'd1;
   end

   // a - rnd(f * b / p), saturated to 64 bits
   always_comb begin
      sneg = ~(f_ff.neg ^ bk_ff.neg);
      am   = {64'd0, a_ff.mag};
      if (a_ff.neg == sneg) begin
         sub_m   = am + md_q;
         sub_neg = a_ff.neg;
      end else if (am >= md_q) begin
         sub_m   = am - md_q;
         sub_neg = a_ff.neg;
      end else begin
         sub_m   = md_q - am;
         sub_neg = sneg;
      end
      sub_lim     = sub_neg ? LIM64_NEG : LIM64_POS;
      sub_res.neg = sub_neg;
      sub_res.mag = (sub_m > sub_lim) ? sub_lim[63:0] : sub_m[63:0];
   end

   // Corner coordinate, saturated to 32 bits
   always_comb begin
      fin_neg    = a_ff.neg ^ bk_ff.neg;
      fin_lim    = fin_neg ? LIM32_NEG : LIM32_POS;
      fin_v      = (md_q > fin_lim) ? fin_lim[31:0] : md_q[31:0];
      corner_val = fin_neg ? (~fin_v + 32'd1) : fin_v;
   end

   always_comb begin
      st_in      = st_ff;
      lcnt_in    = lcnt_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      k_in       = k_ff;
      piv_in     = piv_ff;
      best_in    = best_ff;
      f_in       = f_ff;
      bk_in      = bk_ff;
      a_in       = a_ff;
      tmp_in     = tmp_ff;
      ok_in      = ok_ff;
      rd_addr    = {row_ff, col_ff};
      wr_en      = 1'b0;
      wr_addr    = lcnt_ff;
      wr_data    = to_ent(load_val);
      md_start   = 1'b0;
      md_a       = f_ff.mag;
      md_b       = bk_ff.mag;
      md_d       = best_ff.mag;
      load_done  = 1'b0;
      corner_wr  = 1'b0;
      corner_clr = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (solve_req) begin
               lcnt_in = '0;
               st_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            wr_en = 1'b1;
            if (lcnt_ff == 4'd11) begin
               load_done = 1'b1;
               col_in    = 2'd0;
               row_in    = 2'd0;
               st_in     = S_PRD;
            end else begin
               lcnt_in = lcnt_ff + 4'd1;
            end
         end
         // Pivot search down the column
         S_PRD: begin
            rd_addr = {row_ff, col_ff};
            st_in   = S_PCMP;
         end
         S_PCMP: begin
            if (row_ff == col_ff || rd_data_ff.mag > best_ff.mag) begin
               best_in = rd_data_ff;
               piv_in  = row_ff;
            end
            if (row_ff == 2'd2) begin
               st_in = S_PCHK;
            end else begin
               row_in = row_ff + 2'd1;
               st_in  = S_PRD;
            end
         end
         S_PCHK: begin
            if (best_ff.mag == '0 || best_ff.mag < {28'd0, pivot_floor}) begin
               ok_in      = 1'b0;
               corner_clr = 1'b1;
               st_in      = S_OUT;
            end else if (piv_ff != col_ff) begin
               k_in  = 2'd0;
               st_in = S_SWA;
            end else begin
               row_in = first_row;
               st_in  = S_EF;
            end
         end
         // Row swap, one column at a time
         S_SWA: begin
            rd_addr = {col_ff, k_ff};
            st_in   = S_SWB;
         end
         S_SWB: begin
            tmp_in  = rd_data_ff;
            rd_addr = {piv_ff, k_ff};
            st_in   = S_SWC;
         end
         S_SWC: begin
            wr_en   = 1'b1;
            wr_addr = {col_ff, k_ff};
            wr_data = rd_data_ff;
            st_in   = S_SWD;
         end
         S_SWD: begin
            wr_en   = 1'b1;
            wr_addr = {piv_ff, k_ff};
            wr_data = tmp_ff;
            if (k_ff == 2'd3) begin
               row_in = first_row;
               st_in  = S_EF;
            end else begin
               k_in  = k_ff + 2'd1;
               st_in = S_SWA;
            end
         end
         // Elimination of the other rows
         S_EF: begin
            rd_addr = {row_ff, col_ff};
            st_in   = S_EFL;
         end
         S_EFL: begin
            f_in = rd_data_ff;
            if (rd_data_ff.mag == '0) begin
               if (row_ff == last_row) begin
                  if (col_ff == 2'd2) begin
                     row_in = 2'd0;
                     st_in  = S_FA;
                  end else begin
                     col_in = col_ff + 2'd1;
                     row_in = col_ff + 2'd1;
                     st_in  = S_PRD;
                  end
               end else begin
                  row_in = row_step;
                  st_in  = S_EF;
               end
            end else begin
               k_in  = col_ff;
               st_in = S_EB;
            end
         end
         S_EB: begin
            rd_addr = {col_ff, k_ff};
            st_in   = S_EA;
         end
         S_EA: begin
            bk_in   = rd_data_ff;
            rd_addr = {row_ff, k_ff};
            st_in   = S_EMUL;
         end
         S_EMUL: begin
            a_in     = rd_data_ff;
            md_start = 1'b1;
            st_in    = S_EWAIT;
         end
         S_EWAIT: begin
            if (md_done) begin
               wr_en   = 1'b1;
               wr_addr = {row_ff, k_ff};
               wr_data = sub_res;
               if (k_ff != 2'd3) begin
                  k_in  = k_ff + 2'd1;
                  st_in = S_EB;
               end else if (row_ff != last_row) begin
                  row_in = row_step;
                  st_in  = S_EF;
               end else if (col_ff == 2'd2) begin
                  row_in = 2'd0;
                  st_in  = S_FA;
               end else begin
                  col_in = col_ff + 2'd1;
                  row_in = col_ff + 2'd1;
                  st_in  = S_PRD;
               end
            end
         end
         // Back substitution is a divide by each diagonal entry
         S_FA: begin
            rd_addr = {row_ff, 2'd3};
            st_in   = S_FD;
         end
         S_FD: begin
            a_in    = rd_data_ff;
            rd_addr = {row_ff, row_ff};
            st_in   = S_FMUL;
         end
         S_FMUL: begin
            bk_in    = rd_data_ff;
            md_start = 1'b1;
            md_a     = a_ff.mag;
            md_b     = 64'd1 << 14;
            md_d     = rd_data_ff.mag;
            st_in    = S_FWAIT;
         end
         S_FWAIT: begin
            if (md_done) begin
               corner_wr = 1'b1;
               if (row_ff == 2'd2) begin
                  ok_in = 1'b1;
                  st_in = S_OUT;
               end else begin
                  row_in = row_ff + 2'd1;
                  st_in  = S_FA;
               end
            end
         end
         S_OUT: begin
            if (res_take) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign res_valid  = (st_ff == S_OUT);
   assign res.x      = corner_ff[0];
   assign res.y      = corner_ff[1];
   assign res.z      = corner_ff[2];
   assign res.solved = ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      lcnt_ff <= lcnt_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      k_ff    <= k_in;
      piv_ff  <= piv_in;
      best_ff <= best_in;
      f_ff    <= f_in;
      bk_ff   <= bk_in;
      a_ff    <= a_in;
      tmp_ff  <= tmp_in;
      ok_ff   <= ok_in;
      if (corner_clr) begin
         corner_ff[0] <= '0;
         corner_ff[1] <= '0;
         corner_ff[2] <= '0;
      end else if (corner_wr) begin
         corner_ff[row_ff] <= corner_val;
      end
   end

   // Matrix memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: tb/tb_top.sv
module tb_top;

   localparam int MAX_PLANES  = 16;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int LONG_HOLD   = 20000;
   localparam int SETTLE      = 60;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [lspm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [lspm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lspm_pkg::FLOOR_W-1:0]    csr_data = '0;

   least_squares_plane_meet_top #(.MAX_PLANES(MAX_PLANES)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: normal-equation sums, plane tally and pivot floor
   logic [lspm_pkg::NN_W-1:0]    sum_xx, sum_xy, sum_xz, sum_yy, sum_yz, sum_zz;
   logic [lspm_pkg::DN_W-1:0]    sum_dx, sum_dy, sum_dz;
   int                           plane_tally;
   logic [lspm_pkg::FLOOR_W-1:0] floor_val;

   lspm_pkg::result_type corner_queue[$];
   int         err_count = 0;
   int         planes_sent = 0;
   int         corners_seen = 0;
   int         corners_solved = 0;
   int         cycle_count = 0;
   bit         hold_req = 0;
   bit         send_burst = 0;

   function automatic logic [63:0] mag65(logic signed [64:0] v);
      logic signed [64:0] a;
      a = (v < 0) ? -v : v;
      return a[63:0];
   endfunction

   // Exact Gauss-Jordan with partial pivoting on the accumulated sums
   function automatic lspm_pkg::result_type solve_corner();
      logic signed [64:0]  w[3][4];
      logic signed [64:0]  tmp, f;
      logic [63:0]         pm, fm, km, pv;
      logic [129:0]        num, qm;
      logic signed [131:0] aw, qs, diff, hi_lim, lo_lim;
      logic [31:0]         lim, v;
      logic [31:0]         res[3];
      bit                  neg;
      int                  piv;
      lspm_pkg::result_type r;
      hi_lim = (132'sd1 <<< 63) - 132'sd1;
      lo_lim = -(132'sd1 <<< 63);
      w[0][0] = $signed(sum_xx); w[0][1] = $signed(sum_xy);
      w[0][2] = $signed(sum_xz); w[0][3] = $signed(sum_dx);
      w[1][0] = w[0][1];         w[1][1] = $signed(sum_yy);
      w[1][2] = $signed(sum_yz); w[1][3] = $signed(sum_dy);
      w[2][0] = w[0][2];         w[2][1] = w[1][2];
      w[2][2] = $signed(sum_zz); w[2][3] = $signed(sum_dz);
      r = '0;
      for (int c = 0; c < 3; c++) begin
         piv = c;
         for (int rr = c + 1; rr < 3; rr++)
            if (mag65(w[rr][c]) > mag65(w[piv][c])) piv = rr;
         pv = mag65(w[piv][c]);
         if (pv == 0 || pv < 64'(floor_val)) return r;
         if (piv != c)
            for (int k = 0; k < 4; k++) begin
               tmp = w[c][k]; w[c][k] = w[piv][k]; w[piv][k] = tmp;
            end
         pm = mag65(w[c][c]);
         for (int rr = 0; rr < 3; rr++) begin
            f = w[rr][c];
            if (rr != c && f != 0) begin
               fm = mag65(f);
               for (int k = c; k < 4; k++) begin
                  km = mag65(w[c][k]);
                  num = {66'b0, fm} * {66'b0, km};
                  num = num + {67'b0, pm[63:1]};
                  qm = num / {66'b0, pm};
                  qs = $signed({2'b00, qm});
                  if ((f < 0) != (w[c][k] < 0)) qs = -qs;
                  aw = w[rr][k];
                  diff = aw - qs;
                  if (diff > hi_lim) diff = hi_lim;
                  if (diff < lo_lim) diff = lo_lim;
                  w[rr][k] = diff[64:0];
               end
            end
         end
      end
      // back to Q16.16, saturated
      for (int c = 0; c < 3; c++) begin
         pm = mag65(w[c][c]);
         num = {66'b0, mag65(w[c][3])} << 14;
         num = num + {67'b0, pm[63:1]};
         qm = num / {66'b0, pm};
         neg = (w[c][3] < 0) != (w[c][c] < 0);
         lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         v = (qm > {98'b0, lim}) ? lim : qm[31:0];
         res[c] = neg ? -v : v;
      end
      r.x = res[0]; r.y = res[1]; r.z = res[2]; r.solved = 1'b1;
      return r;
   endfunction

   function automatic void clear_sums();
      sum_xx = '0; sum_xy = '0; sum_xz = '0; sum_yy = '0; sum_yz = '0; sum_zz = '0;
      sum_dx = '0; sum_dy = '0; sum_dz = '0;
      plane_tally = 0;
   endfunction

   // Fold one accepted plane into the sums; returns 1 with the corner on a last plane
   function automatic bit take_plane(logic signed [15:0] nx, logic signed [15:0] ny,
                                     logic signed [15:0] nz, logic signed [31:0] off,
                                     bit last, output lspm_pkg::result_type corner);
      longint p;
      corner = '0;
      if (plane_tally < MAX_PLANES) begin
         p = longint'(nx) * longint'(nx); sum_xx = sum_xx + p[lspm_pkg::NN_W-1:0];
         p = longint'(nx) * longint'(ny); sum_xy = sum_xy + p[lspm_pkg::NN_W-1:0];
         p = longint'(nx) * longint'(nz); sum_xz = sum_xz + p[lspm_pkg::NN_W-1:0];
         p = longint'(ny) * longint'(ny); sum_yy = sum_yy + p[lspm_pkg::NN_W-1:0];
         p = longint'(ny) * longint'(nz); sum_yz = sum_yz + p[lspm_pkg::NN_W-1:0];
         p = longint'(nz) * longint'(nz); sum_zz = sum_zz + p[lspm_pkg::NN_W-1:0];
         p = longint'(off) * longint'(nx); sum_dx = sum_dx + p[lspm_pkg::DN_W-1:0];
         p = longint'(off) * longint'(ny); sum_dy = sum_dy + p[lspm_pkg::DN_W-1:0];
         p = longint'(off) * longint'(nz); sum_dz = sum_dz + p[lspm_pkg::DN_W-1:0];
         plane_tally++;
      end
      if (!last) return 0;
      corner = solve_corner();
      clear_sums();
      return 1;
   endfunction

   // Offer one plane, wait for its transfer, then record the expected corner if it was the last
   task automatic send_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [31:0] off, bit last,
                             bit typed = 0, lspm_pkg::result_type typed_corner = '0);
      int                   gap;
      lspm_pkg::result_type corner;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {off, nz, ny, nx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      planes_sent++;
      if (take_plane(nx, ny, nz, off, last, corner))
         corner_queue.insert(corner_queue.size(), typed ? typed_corner : corner);
   endtask

   task automatic write_floor(logic [lspm_pkg::FLOOR_W-1:0] value);
      req_tvalid <= 1'b0;
      while (corner_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      floor_val = value;
   endtask

   function automatic logic [15:0] rand_comp(int kind);
      case (kind)
         0: return 16'($signed($urandom_range(0, 32768)) - 16384);
         1: return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_offset();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
   endfunction

   // One set of planes; kind picks well-formed, degenerate or raw content
   task automatic send_set(int n);
      int          kind;
      logic [15:0] bx, by, bz;
      kind = $urandom_range(0, 9);
      bx = rand_comp(0); by = rand_comp(0); bz = rand_comp(0);
      send_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         if (kind < 6)
            send_plane(rand_comp(0), rand_comp(0), rand_comp(0), rand_offset(), i == n - 1);
         else if (kind < 8)
            // normals share y and z, x flips sign: rank two at most
            send_plane(($urandom_range(0, 1) != 0) ? bx : -bx, by, bz, rand_offset(),
                       i == n - 1);
         else if (kind == 8)
            // x always set, z set now and then, y zero: normals in the x-z plane
            send_plane(rand_comp(1), 16'd0, ($urandom_range(0, 3) == 0) ? rand_comp(1) : 16'd0,
                       rand_offset(), i == n - 1);
         else
            send_plane(rand_comp(2), rand_comp(2), rand_comp(2), $urandom, i == n - 1);
      end
   endtask

   task automatic run_sets(int planes);
      int n, done;
      done = 0;
      while (done < planes) begin
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(1, 2);
            1:       n = $urandom_range(MAX_PLANES + 1, MAX_PLANES + 4);
            default: n = $urandom_range(3, 9);
         endcase
         send_set(n);
         done += n;
      end
   endtask

   typedef struct {
      logic [15:0] nx, ny, nz;
      logic [31:0] off;
      bit          last;
      bit          typed;
      lspm_pkg::result_type corner;
   } plane_row_type;

   plane_row_type dir_rows[20];

   // Stall pattern of the result side, with one long hold on request
   initial begin
      int wait_n;
      wait_n = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            wait_n = LONG_HOLD;
         end
         if (rsp_tvalid && rsp_tready && wait_n == 0)
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (wait_n > 0) begin
            wait_n--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      lspm_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x = rsp_tdata[31:0];
         got.y = rsp_tdata[63:32];
         got.z = rsp_tdata[95:64];
         got.solved = rsp_tuser;
         corners_seen++;
         if (got.solved) corners_solved++;
         if (corner_queue.size() == 0) begin
            $display("%0t: unexpected corner transfer x=%h y=%h z=%h solved=%b",
                     $time, got.x, got.y, got.z, got.solved);
            err_count++;
         end else begin
            want = corner_queue.pop_front();
            if (got.x !== want.x) begin
               $display("%0t: corner_x expected %h actual %h", $time, want.x, got.x);
               err_count++;
            end
            if (got.y !== want.y) begin
               $display("%0t: corner_y expected %h actual %h", $time, want.y, got.y);
               err_count++;
            end
            if (got.z !== want.z) begin
               $display("%0t: corner_z expected %h actual %h", $time, want.z, got.z);
               err_count++;
            end
            if (got.solved !== want.solved) begin
               $display("%0t: solved expected %b actual %b", $time, want.solved, got.solved);
               err_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("least_squares_plane_meet_top verification failed");
         $finish;
      end
   end

   initial begin
      // Directed planes: zero set, axis planes, offset extremes,
      // rank-deficient sets, oblique and out-of-range normals
      dir_rows = '{
         '{16'd0, 16'd0, 16'd0, 32'd0, 1, 1, '{32'd0, 32'd0, 32'd0, 1'b0}},
         '{16'd16384, 16'd0, 16'd0, 32'h0001_0000, 0, 0, '0},
         '{16'd0, 16'd16384, 16'd0, 32'h0002_0000, 0, 0, '0},
         '{16'd0, 16'd0, 16'd16384, 32'hFFFD_0000, 1, 1,
           '{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b1}},
         '{16'hC000, 16'd0, 16'd0, 32'h8000_0000, 0, 0, '0},
         '{16'd0, 16'd16384, 16'd0, 32'h7FFF_FFFF, 0, 0, '0},
         '{16'd0, 16'd0, 16'd16384, 32'h8000_0000, 1, 1,
           '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1}},
         '{16'd16384, 16'd0, 16'd0, 32'h0001_0000, 0, 0, '0},
         '{16'd16384, 16'd0, 16'd0, 32'h0003_0000, 1, 1, '{32'd0, 32'd0, 32'd0, 1'b0}},
         '{16'd11585, 16'd11585, 16'd0, 32'h0000_8000, 0, 0, '0},
         '{16'd0, 16'd11585, 16'd11585, 32'hFFFF_0000, 0, 0, '0},
         '{16'd11585, 16'd0, 16'd11585, 32'h0002_0000, 0, 0, '0},
         '{16'd9459, 16'd9459, 16'd9459, 32'h0000_1234, 1, 0, '0},
         '{16'h8000, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 0, 0, '0},
         '{16'h7FFF, 16'h8000, 16'd0, 32'h8000_0000, 0, 0, '0},
         '{16'd0, 16'd0, 16'h7FFF, 32'h0000_0001, 1, 0, '0},
         '{16'd0, 16'd0, 16'd0, 32'h1234_5678, 0, 0, '0},
         '{16'd16384, 16'd16384, 16'd16384, 32'h0001_0000, 1, 1,
           '{32'd0, 32'd0, 32'd0, 1'b0}},
         '{16'd16384, 16'd0, 16'd0, 32'd0, 0, 0, '0},
         '{16'd0, 16'd16384, 16'd0, 32'd0, 1, 1, '{32'd0, 32'd0, 32'd0, 1'b0}}
      };
      clear_sums();
      floor_val = 36'd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_plane(dir_rows[i].nx, dir_rows[i].ny, dir_rows[i].nz, dir_rows[i].off,
                    dir_rows[i].last, dir_rows[i].typed, dir_rows[i].corner);

      // random phases over several floors
      run_sets(250);
      write_floor(36'd0);
      run_sets(200);
      write_floor({lspm_pkg::FLOOR_W{1'b1}});
      run_sets(100);
      write_floor(lspm_pkg::FLOOR_W'({$urandom_range(0, 15), $urandom})
                  >> $urandom_range(4, 12));
      run_sets(150);
      // long result-side hold while planes keep coming
      hold_req = 1;
      run_sets(150);
      write_floor(36'd1);
      run_sets(250);

      req_tvalid <= 1'b0;
      while (corner_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d planes, checked %0d corners (%0d solved, %0d rank deficient)",
               planes_sent, corners_seen, corners_solved, corners_seen - corners_solved);
      $display("Floors 1, 0, all ones and a random value; long output hold included");
      if (err_count == 0)
         $display("least_squares_plane_meet_top verification clean");
      else
         $display("least_squares_plane_meet_top verification failed");
      $finish;
   end

endmodule
